### hw/rtl/pwm_d2a_pkg.sv
// ----------------------------------------------------------------------------
// pwm_d2a_pkg
// Shared widths, constants, register codes and types for the duty-to-angle
// converter.
// ----------------------------------------------------------------------------
package pwm_d2a_pkg;

    localparam int DUTY_W    = 10;
    localparam int ANGLE_W   = 19;
    localparam int OFFSET_W  = 20;
    localparam int SUM_W     = 21;
    localparam int PROD_W    = 29;
    localparam int DIV_STEPS = 29;
    localparam int CNT_W     = 5;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    localparam int FULL_TURN     = 360000;
    localparam int LOW_INIT_RST  = 0;
    localparam int HIGH_INIT_RST = 1000;

    localparam logic [REG_IDX_W-1:0] REG_AUTO_RECAL = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INVERT     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOW_INIT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_INIT  = 3'd4;

    typedef struct packed {
        logic                       auto_recal;
        logic signed [OFFSET_W-1:0] offset;
        logic                       invert;
    } t_cfg;

    typedef struct packed {
        logic              ld_low;
        logic              ld_high;
        logic [DUTY_W-1:0] value;
    } t_bound_load;

endpackage

### hw/rtl/pwm_d2a_regs.sv
// ----------------------------------------------------------------------------
// pwm_d2a_regs
// APB register file: mode bits, angle offset and calibration bound presets.
// ----------------------------------------------------------------------------
module pwm_d2a_regs
    import pwm_d2a_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg,
    output t_bound_load       o_bload
);

    logic                       r_auto_recal;
    logic signed [OFFSET_W-1:0] r_offset;
    logic                       r_invert;
    logic [DUTY_W-1:0]          r_low_init;
    logic [DUTY_W-1:0]          r_high_init;
    logic                       w_wr;
    logic [REG_IDX_W-1:0]       w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_recal <= 1'b0;
            r_offset     <= '0;
            r_invert     <= 1'b0;
            r_low_init   <= DUTY_W'(LOW_INIT_RST);
            r_high_init  <= DUTY_W'(HIGH_INIT_RST);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_AUTO_RECAL: r_auto_recal <= pwdata[0];
                REG_OFFSET:     r_offset     <= pwdata[OFFSET_W-1:0];
                REG_INVERT:     r_invert     <= pwdata[0];
                REG_LOW_INIT:   r_low_init   <= pwdata[DUTY_W-1:0];
                REG_HIGH_INIT:  r_high_init  <= pwdata[DUTY_W-1:0];
                default:        ;
            endcase
        end
    end

    // preset writes also reload the live bounds
    always_comb begin
        o_bload.ld_low  = w_wr && (w_idx == REG_LOW_INIT);
        o_bload.ld_high = w_wr && (w_idx == REG_HIGH_INIT);
        o_bload.value   = pwdata[DUTY_W-1:0];
    end

    always_comb begin
        o_cfg.auto_recal = r_auto_recal;
        o_cfg.offset     = r_offset;
        o_cfg.invert     = r_invert;
    end

    always_comb begin
        unique case (w_idx)
            REG_AUTO_RECAL: prdata = {{(APB_DW-1){1'b0}}, r_auto_recal};
            REG_OFFSET:     prdata = {{(APB_DW-OFFSET_W){r_offset[OFFSET_W-1]}}, r_offset};
            REG_INVERT:     prdata = {{(APB_DW-1){1'b0}}, r_invert};
            REG_LOW_INIT:   prdata = {{(APB_DW-DUTY_W){1'b0}}, r_low_init};
            REG_HIGH_INIT:  prdata = {{(APB_DW-DUTY_W){1'b0}}, r_high_init};
            default:        prdata = '0;
        endcase
    end

endmodule

### hw/rtl/pwm_d2a_div.sv
// ----------------------------------------------------------------------------
// pwm_d2a_div
// Bit-serial restoring divider: floor(num * 360000 / den), one quotient bit
// per cycle, numerator not above denominator.
// ----------------------------------------------------------------------------
module pwm_d2a_div
    import pwm_d2a_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DUTY_W-1:0]  i_num,
    input  logic [DUTY_W-1:0]  i_den,
    output logic               o_done,
    output logic [ANGLE_W-1:0] o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_dividend;
    logic [DUTY_W-1:0] r_den;
    logic [DUTY_W-1:0] r_rem;
    logic [ANGLE_W-1:0] r_quo;
    logic [DUTY_W:0]   w_trial;
    logic              w_fits;
    logic [DUTY_W:0]   w_diff;

    // next dividend bit shifted into the partial remainder
    assign w_trial = {r_rem, r_dividend[PROD_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= PROD_W'(i_num) * PROD_W'(FULL_TURN);
            r_den      <= i_den;
            r_rem      <= '0;
            r_quo      <= '0;
        end else if (r_busy) begin
            r_dividend <= {r_dividend[PROD_W-2:0], 1'b0};
            r_rem      <= w_fits ? w_diff[DUTY_W-1:0] : w_trial[DUTY_W-1:0];
            r_quo      <= {r_quo[ANGLE_W-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### hw/rtl/pwm_d2a_wrap.sv
// ----------------------------------------------------------------------------
// pwm_d2a_wrap
// Offset add, wrap onto the circle and optional inversion, three register
// stages.
// ----------------------------------------------------------------------------
module pwm_d2a_wrap
    import pwm_d2a_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ANGLE_W-1:0]         i_term,
    input  logic signed [OFFSET_W-1:0] i_offset,
    input  logic                       i_invert,
    output logic                       o_done,
    output logic [ANGLE_W-1:0]         o_angle
);

    localparam logic signed [SUM_W-1:0] SUM_ONE = SUM_W'(FULL_TURN);
    localparam logic signed [SUM_W-1:0] SUM_TWO = SUM_W'(2 * FULL_TURN);
    localparam logic [ANGLE_W-1:0]      ANG_ONE = ANGLE_W'(FULL_TURN);

    logic [2:0]               r_vld;
    logic signed [SUM_W-1:0]  r_sum;
    logic [ANGLE_W-1:0]       r_wrap;
    logic [ANGLE_W-1:0]       r_angle;
    logic signed [SUM_W-1:0]  w_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= $signed({2'b00, i_term}) + $signed({i_offset[OFFSET_W-1], i_offset});
        end
    end

    // sum range keeps at most two turns to remove or add
    always_comb begin
        if (r_sum >= SUM_TWO) begin
            w_wrap = r_sum - SUM_TWO;
        end else if (r_sum >= SUM_ONE) begin
            w_wrap = r_sum - SUM_ONE;
        end else if (r_sum > 0) begin
            w_wrap = r_sum;
        end else if (r_sum >= -SUM_ONE) begin
            w_wrap = r_sum + SUM_ONE;
        end else begin
            w_wrap = r_sum + SUM_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wrap  <= w_wrap[ANGLE_W-1:0];
        r_angle <= i_invert ? (ANG_ONE - r_wrap) : r_wrap;
    end

    assign o_done  = r_vld[2];
    assign o_angle = r_angle;

endmodule

### hw/rtl/pwm_duty_to_angle_autocal_unit.sv
// ----------------------------------------------------------------------------
// pwm_duty_to_angle_autocal_unit
// PWM duty to absolute angle in millidegrees with self-widening calibration.
// ----------------------------------------------------------------------------
// One duty transaction is taken at a time. The bound update and clamp happen at
// the accepting edge. The result then passes operand preparation, the load of
// the divider with the scaled numerator, the 29-step bit-serial divider (one
// quotient bit per cycle), the offset, wrap and invert registers, the hand-over
// to the output state and the move into the output register, which waits while
// an earlier result is still stalled there. The input stall drops at the edge
// that loads the output register, even while the result is still stalled
// there.
// ----------------------------------------------------------------------------
module pwm_duty_to_angle_autocal_unit
    import pwm_d2a_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [DUTY_W-1:0]  i_duty_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ANGLE_W-1:0] o_angle_out,
    output logic               o_span_error,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_WRAP  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    t_cfg               w_cfg;
    t_bound_load        w_bload;
    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [DUTY_W-1:0]  r_low;
    logic [DUTY_W-1:0]  r_high;
    logic [DUTY_W-1:0]  r_duty;
    logic [DUTY_W-1:0]  r_num;
    logic [DUTY_W-1:0]  r_den;
    logic               r_err;
    logic               r_out_valid;
    logic [ANGLE_W-1:0] r_angle_out;
    logic               r_span_error;
    logic               w_in_acc;
    logic               w_out_load;
    logic               w_div_done;
    logic [ANGLE_W-1:0] w_quo;
    logic [ANGLE_W-1:0] w_term;
    logic               w_wrap_done;
    logic [ANGLE_W-1:0] w_angle;

    pwm_d2a_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg),
        .o_bload (w_bload)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    // bound update and clamp on acceptance, lower test first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= DUTY_W'(LOW_INIT_RST);
            r_high <= DUTY_W'(HIGH_INIT_RST);
        end else if (w_in_acc) begin
            if (i_duty_sample < r_low) begin
                if (w_cfg.auto_recal) begin
                    r_low <= i_duty_sample;
                end
            end else if (i_duty_sample > r_high) begin
                if (w_cfg.auto_recal) begin
                    r_high <= i_duty_sample;
                end
            end
        end else begin
            if (w_bload.ld_low) begin
                r_low <= w_bload.value;
            end
            if (w_bload.ld_high) begin
                r_high <= w_bload.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (i_duty_sample < r_low) begin
                r_duty <= w_cfg.auto_recal ? i_duty_sample : r_low;
            end else if (i_duty_sample > r_high) begin
                r_duty <= w_cfg.auto_recal ? i_duty_sample : r_high;
            end else begin
                r_duty <= i_duty_sample;
            end
        end
    end

    // with reversed bounds the numerator is zero or negative and the span negative: use magnitudes
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            r_err <= (r_low == r_high);
            if (r_low <= r_high) begin
                r_num <= r_duty - r_low;
                r_den <= r_high - r_low;
            end else begin
                r_num <= r_low - r_duty;
                r_den <= r_low - r_high;
            end
        end
    end

    pwm_d2a_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_START),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_term = r_err ? '0 : w_quo;

    pwm_d2a_wrap u_wrap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_done),
        .i_term   (w_term),
        .i_offset (w_cfg.offset),
        .i_invert (w_cfg.invert),
        .o_done   (w_wrap_done),
        .o_angle  (w_angle)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc) n_state = ST_PREP;
            ST_PREP:  n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV:   if (w_div_done) n_state = ST_WRAP;
            ST_WRAP:  if (w_wrap_done) n_state = ST_OUT;
            ST_OUT:   if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_angle_out  <= w_angle;
            r_span_error <= r_err;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_angle_out  = r_angle_out;
    assign o_span_error = r_span_error;

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("output transaction appeared without a finished item");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("divider finished outside its state");

    a_wrap_in_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wrap_done |-> r_state == ST_WRAP)
        else $error("wrap stage finished outside its state");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_angle_out <= ANGLE_W'(FULL_TURN))
        else $error("angle beyond a full turn");

endmodule
